FILE: rtl/rws_pkg.sv
// Shared types and constants for the roulette wheel selector.
package rws_pkg;

    localparam int FRAC_BITS = 16;   // random fraction is scaled by 2^16 - 1
    localparam int SLOT_BITS = 6;
    localparam int COUNT_BITS = 7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/roulette_wheel_selector_unit.sv
// Roulette wheel selector: score memory, running total and draw scan.
//
// Usage
//   Input channel s_*: one request per accepted valid/ready beat. A load
//   request (opcode 0) writes one member score and adjusts the running
//   total; it returns nothing. A draw request (opcode 1) scans members
//   0 .. min(member_count, MAX_MEMBERS)-1, one score memory read per cycle, and
//   returns one result on m_* with the first member whose running sum times
//   65535 exceeds random_value times the total (found=0 if none does).
//   The single read port of the score memory feeds the running sum one score
//   per cycle. Requests are handled one at a time.
//   Config: cfg_we/cfg_wdata write member_count (reset 64). The user must
//   write it only while idle; the block does not enforce this.
//   Reset: synchronous, active low. After reset the score memory is swept
//   to zero, and s_ready stays low until the sweep ends.
//   Stall: a result waits in the output register; loads keep flowing, and a
//   later draw holds its result until the earlier one has been taken.
module roulette_wheel_selector_unit
    import rws_pkg::*;
#(
    parameter int MAX_MEMBERS = 64,
    parameter int SCORE_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [SLOT_BITS-1:0]  s_member_slot,
    input  logic [FRAC_BITS-1:0]  s_score_value,
    input  logic [FRAC_BITS-1:0]  s_random_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_BITS-1:0]  m_chosen_member,
    output logic                  m_found
);

    localparam int AW = $clog2(MAX_MEMBERS);
    localparam int CW = $clog2(MAX_MEMBERS + 1);
    localparam int IW = (CW > SLOT_BITS) ? CW : SLOT_BITS;
    localparam int LW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
    localparam int TW = SCORE_BITS + AW;
    localparam int PW = TW + FRAC_BITS;

    // score memory
    logic [SCORE_BITS-1:0] mem [MAX_MEMBERS];
    logic [SCORE_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [SCORE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;

    state_t state_reg, state_next;

    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [TW-1:0]         total_reg, total_next;
    logic [LW-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                  v1_reg, v1_next;
    logic                  v2_reg, v2_next;
    logic                  m_valid_reg, m_valid_next;

    logic [IW-1:0]         slot_reg, slot_next;
    logic                  inr_reg, inr_next;
    logic [SCORE_BITS-1:0] score_reg, score_next;
    logic [FRAC_BITS-1:0]  rnd_reg, rnd_next;
    logic [PW-1:0]         thr_reg, thr_next;
    logic [LW-1:0]         idx1_reg, idx1_next;
    logic [LW-1:0]         idx2_reg, idx2_next;
    logic [TW-1:0]         running_reg, running_next;
    logic                  hit_found_reg, hit_found_next;
    logic [SLOT_BITS-1:0]  hit_idx_reg, hit_idx_next;
    logic [SLOT_BITS-1:0]  m_chosen_reg, m_chosen_next;
    logic                  m_found_reg, m_found_next;

    logic [IW-1:0] slot_ext;
    logic [LW-1:0] limit;
    logic [PW-1:0] scaled;
    logic          hit;
    logic          last;
    logic          accept;
    logic          out_free;

    assign slot_ext = IW'(s_member_slot);
    assign limit    = (LW'(count_reg) > LW'(MAX_MEMBERS)) ? LW'(MAX_MEMBERS)
                                                          : LW'(count_reg);
    // running * 65535 as shift and subtract
    assign scaled   = {running_reg, {FRAC_BITS{1'b0}}} - PW'(running_reg);
    assign hit      = v2_reg && (scaled > thr_reg);
    assign last     = v2_reg && ((idx2_reg + LW'(1)) == limit);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_chosen_member = m_chosen_reg;
    assign m_found         = m_found_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == AW'(MAX_MEMBERS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_opcode == OP_LOAD) ? ST_LOAD : ST_MUL;
                end
            end
            ST_LOAD: state_next = ST_IDLE;
            ST_MUL: begin
                state_next = (limit == '0) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                if (hit || last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        clr_cnt_next   = clr_cnt_reg;
        count_next     = cfg_we ? cfg_wdata : count_reg;
        total_next     = total_reg;
        rd_cnt_next    = rd_cnt_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        slot_next      = slot_reg;
        inr_next       = inr_reg;
        score_next     = score_reg;
        rnd_next       = rnd_reg;
        thr_next       = thr_reg;
        idx1_next      = idx1_reg;
        idx2_next      = idx2_reg;
        running_next   = running_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        m_chosen_next  = m_chosen_reg;
        m_found_next   = m_found_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg[AW-1:0];
        mem_wdata      = score_reg;
        mem_raddr      = rd_cnt_reg[AW-1:0];
        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_IDLE: begin
                mem_raddr = slot_ext[AW-1:0];
                if (accept) begin
                    slot_next  = slot_ext;
                    inr_next   = (slot_ext < IW'(MAX_MEMBERS));
                    score_next = SCORE_BITS'(s_score_value);
                    rnd_next   = s_random_value;
                end
            end
            ST_LOAD: begin
                // old score of the slot is in rdata_reg
                if (inr_reg) begin
                    mem_we     = 1'b1;
                    total_next = total_reg - TW'(rdata_reg) + TW'(score_reg);
                end
            end
            ST_MUL: begin
                thr_next       = {{TW{1'b0}}, rnd_reg} * {{FRAC_BITS{1'b0}}, total_reg};
                rd_cnt_next    = '0;
                v1_next        = 1'b0;
                v2_next        = 1'b0;
                running_next   = '0;
                hit_found_next = 1'b0;
                hit_idx_next   = '0;
            end
            ST_SCAN: begin
                if (hit || last) begin
                    hit_found_next = hit;
                    hit_idx_next   = hit ? idx2_reg[SLOT_BITS-1:0] : '0;
                end
                if (rd_cnt_reg < limit) begin
                    v1_next     = 1'b1;
                    idx1_next   = rd_cnt_reg;
                    rd_cnt_next = rd_cnt_reg + LW'(1);
                end else begin
                    v1_next = 1'b0;
                end
                v2_next = v1_reg;
                if (v1_reg) begin
                    running_next = running_reg + TW'(rdata_reg);
                    idx2_next    = idx1_reg;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_chosen_next = hit_idx_reg;
                    m_found_next  = hit_found_reg;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            count_reg   <= COUNT_BITS'(64);
            total_reg   <= '0;
            rd_cnt_reg  <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            rd_cnt_reg  <= rd_cnt_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        slot_reg      <= slot_next;
        inr_reg       <= inr_next;
        score_reg     <= score_next;
        rnd_reg       <= rnd_next;
        thr_reg       <= thr_next;
        idx1_reg      <= idx1_next;
        idx2_reg      <= idx2_next;
        running_reg   <= running_next;
        hit_found_reg <= hit_found_next;
        hit_idx_reg   <= hit_idx_next;
        m_chosen_reg  <= m_chosen_next;
        m_found_reg   <= m_found_next;
    end

    // score memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

FILE: rtl/rws_checker.sv
// Port-level checks for the roulette wheel selector, bound to the top level.
module rws_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_chosen_member,
    input logic       m_found
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chosen_member) && $stable(m_found))
        else $error("result changed while stalled");

    // a miss always reports member zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_chosen_member == 6'd0)
        else $error("miss with nonzero member");

    // s_ready drops after each accepted request, so none is accepted back to back
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

    // memory clearing pass runs right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready or result right after reset");

endmodule

bind roulette_wheel_selector_unit rws_port_checks u_rws_checker (.*);

FILE: verif/rws_checker.sv
// Checker for the roulette wheel selector: predicts each draw and compares results.
`timescale 1ns / 100ps

module rws_checker
    import rws_pkg::*;
#(
    parameter int MAX_MEMBERS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [SLOT_BITS-1:0]  s_member_slot,
    input  logic [FRAC_BITS-1:0]  s_score_value,
    input  logic [FRAC_BITS-1:0]  s_random_value,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [SLOT_BITS-1:0]  m_chosen_member,
    input  logic                  m_found,
    output int                    mismatch_count,
    output int                    picks_outstanding,
    output int                    picks_checked,
    output int                    picks_hit
);

    typedef struct packed {
        logic                 found;
        logic [SLOT_BITS-1:0] member;
    } pick_t;

    logic [FRAC_BITS-1:0]  score_table [MAX_MEMBERS];
    logic [21:0]           score_sum;
    logic [COUNT_BITS-1:0] wheel_size;
    pick_t                 expected_picks [$];

    initial begin
        mismatch_count    = 0;
        picks_outstanding = 0;
        picks_checked     = 0;
        picks_hit         = 0;
    end

    // First member whose running sum * 65535 beats rnd * total
    function automatic pick_t spin_wheel(logic [FRAC_BITS-1:0] rnd);
        pick_t       res;
        logic [37:0] bar;
        logic [21:0] acc;
        int          lim;
        res = '0;
        acc = '0;
        lim = (int'(wheel_size) > MAX_MEMBERS) ? MAX_MEMBERS : int'(wheel_size);
        bar = 38'(rnd) * 38'(score_sum);
        for (int j = 0; j < lim; j++) begin
            acc = acc + 22'(score_table[j]);
            if (38'(acc) * 38'd65535 > bar) begin
                res.found  = 1'b1;
                res.member = SLOT_BITS'(j);
                return res;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        pick_t want;
        if (!aresetn) begin
            foreach (score_table[i]) score_table[i] = '0;
            score_sum  = '0;
            wheel_size = COUNT_BITS'(64);
            expected_picks.delete();
        end else begin
            if (cfg_we) begin
                wheel_size = cfg_wdata;
            end
            // compare first: a result always belongs to an older draw
            if (m_valid && m_ready) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch("unexpected result, found", m_found, 0);
                end else begin
                    want = expected_picks.pop_front();
                    picks_checked++;
                    if (want.found) picks_hit++;
                    if (m_found !== want.found)
                        report_mismatch("found", m_found, want.found);
                    if (m_chosen_member !== want.member)
                        report_mismatch("chosen_member", m_chosen_member, want.member);
                end
            end
            if (s_valid && s_ready) begin
                if (s_opcode == OP_LOAD) begin
                    score_sum = score_sum - 22'(score_table[s_member_slot])
                              + 22'(s_score_value);
                    score_table[s_member_slot] = s_score_value;
                end else begin
                    expected_picks.insert(expected_picks.size(),
                                          spin_wheel(s_random_value));
                end
            end
        end
        picks_outstanding = expected_picks.size();
    end

endmodule

FILE: verif/tb_roulette_wheel_selector_unit.sv
// Testbench top for the roulette wheel selector: stimulus, reset, clock and verdict.
`timescale 1ns / 100ps

module tb_roulette_wheel_selector_unit;
    import rws_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [COUNT_BITS-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic [SLOT_BITS-1:0]  s_member_slot;
    logic [FRAC_BITS-1:0]  s_score_value;
    logic [FRAC_BITS-1:0]  s_random_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [SLOT_BITS-1:0]  m_chosen_member;
    logic                  m_found;

    int mismatch_count;
    int picks_outstanding;
    int picks_checked;
    int picks_hit;

    bit s_idle_on;
    bit m_idle_on;
    bit reset_done;
    int loads_sent;
    int draws_sent;
    int size_settings;
    int wheel_cfg;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    roulette_wheel_selector_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_member_slot   (s_member_slot),
        .s_score_value   (s_score_value),
        .s_random_value  (s_random_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chosen_member (m_chosen_member),
        .m_found         (m_found)
    );

    rws_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_member_slot     (s_member_slot),
        .s_score_value     (s_score_value),
        .s_random_value    (s_random_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_chosen_member   (m_chosen_member),
        .m_found           (m_found),
        .mismatch_count    (mismatch_count),
        .picks_outstanding (picks_outstanding),
        .picks_checked     (picks_checked),
        .picks_hit         (picks_hit)
    );

    // One request; valid holds until accepted
    task automatic send_request(logic op, int slot, int score, int rnd);
        int gap;
        gap = s_idle_on ? $urandom_range(0, 14) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_member_slot  <= SLOT_BITS'(slot);
        s_score_value  <= FRAC_BITS'(score);
        s_random_value <= FRAC_BITS'(rnd);
        do @(posedge aclk); while (!s_ready);
        if (op == OP_LOAD) loads_sent++;
        else draws_sent++;
    endtask

    task automatic load_score(int slot, int score);
        send_request(OP_LOAD, slot, score, $urandom_range(0, 65535));
    endtask

    task automatic draw(int rnd);
        send_request(OP_DRAW, $urandom_range(0, 63), $urandom_range(0, 65535), rnd);
    endtask

    // Drain all results, let a trailing load finish, then write member_count
    task automatic set_wheel_size(int count);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (picks_outstanding != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_BITS'(count);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        wheel_cfg = count;
        size_settings++;
    endtask

    function automatic int pick_score();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2, 3:    return $urandom_range(0, 255);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int pick_random();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Result side: random stall before each result
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (reset_done);
        forever begin
            gap = m_idle_on ? $urandom_range(0, 14) : 0;
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #4_000_000;
        $display("Timeout: %0d results still expected", picks_outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int count;
        int lim;
        int slot;
        int waited;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_opcode       = OP_LOAD;
        s_member_slot  = '0;
        s_score_value  = '0;
        s_random_value = '0;
        s_idle_on      = 1'b0;
        m_idle_on      = 1'b0;
        loads_sent     = 0;
        draws_sent     = 0;
        size_settings  = 0;
        wheel_cfg      = 64;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        reset_done = 1'b1;

        // directed part
        set_wheel_size(64);
        draw(0);                    // zero total
        draw(65535);
        load_score(0, 65535);
        load_score(63, 65535);
        draw(0);
        draw(65535);                // full-scale random never passes
        draw(32767);
        draw(32768);
        load_score(0, 0);           // reload replaces the old score
        draw(0);
        load_score(31, 1);
        draw(1);
        set_wheel_size(32);         // slot 63 is outside the scan
        draw(0);
        draw(40000);
        set_wheel_size(0);          // nothing scanned
        draw(0);
        set_wheel_size(127);        // saturates at 64 members
        draw(1);
        draw(65534);
        set_wheel_size(1);
        load_score(0, 65535);
        draw(0);
        draw(30000);
        load_score(63, 0);
        load_score(31, 0);
        draw(65534);

        // random part: phases with different member counts and idle patterns
        for (int phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 7))
                0:       count = 1;
                1:       count = 64;
                2:       count = 127;
                3:       count = $urandom_range(0, 2);
                4:       count = $urandom_range(65, 126);
                default: count = $urandom_range(1, 64);
            endcase
            set_wheel_size(count);
            s_idle_on = ($urandom_range(0, 3) != 0);
            m_idle_on = ($urandom_range(0, 3) != 0);
            lim = (wheel_cfg > 64) ? 64 : wheel_cfg;
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(0, 9) < 4) begin
                    draw(pick_random());
                end else begin
                    if (lim > 0 && $urandom_range(0, 4) != 0)
                        slot = $urandom_range(0, lim - 1);
                    else
                        slot = $urandom_range(0, 63);
                    load_score(slot, pick_score());
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        waited = 0;
        while (picks_outstanding != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (80) @(negedge aclk);

        $display("Sent %0d loads and %0d draws over %0d member-count settings;",
                 loads_sent, draws_sent, size_settings);
        $display("checked %0d results, %0d of them picked a member, %0d left unanswered.",
                 picks_checked, picks_hit, picks_outstanding);
        if (mismatch_count == 0 && picks_outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: roulette_wheel_selector_unit.f
rtl/rws_pkg.sv
rtl/roulette_wheel_selector_unit.sv
rtl/rws_checker.sv
verif/rws_checker.sv
verif/tb_roulette_wheel_selector_unit.sv
